// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the color map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another on the same edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/lut3d_pkg.sv -----
// Shared types, constants and codes of the 3D LUT color mapper.
package lut3d_pkg;

    localparam int MAX_GRID_DEF = 33;
    localparam int CH_W         = 16;
    localparam int ENT_W        = 18;
    localparam int SIZE_W       = 6;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 6;
    localparam int IN_DATA_W    = 120;
    localparam int OUT_DATA_W   = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LUT_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUT_MODE = 8'd1;

    // Command and mode codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;
    localparam logic MODE_CURVE = 1'b0;
    localparam logic MODE_CUBE  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd33;

    typedef logic signed [ENT_W-1:0] t_ent;

    // Per-pixel info that rides alongside the datapath
    typedef struct packed {
        logic                  last;
        logic                  pass;
        logic                  mode;
        logic [2:0][CH_W-1:0]  pix;
        logic [2:0][CH_W-1:0]  fr;
    } t_side;

    typedef struct packed {
        logic                  last;
        logic [2:0][CH_W-1:0]  rgb;
    } t_result;

    // Clamp a signed entry value to 0..65535
    function automatic logic [CH_W-1:0] clamp16(input t_ent v);
        logic [CH_W-1:0] res;
        if (v[ENT_W-1]) begin
            res = '0;
        end else if (v[ENT_W-2:CH_W] != '0) begin
            res = '1;
        end else begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/lut3d_ram.sv -----
// Table memory with one write port and two registered read ports.
module lut3d_ram #(
    parameter int DEPTH = 35937,
    parameter int AW    = 16,
    parameter int DW    = 54
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write one entry per load
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read two corners every cycle
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/lut3d_lerp.sv -----
// Three-stage linear blend: floor((a*(65536-f) + b*f) / 65536).
module lut3d_lerp (
    input  logic                   i_clk,
    input  lut3d_pkg::t_ent        i_a,
    input  lut3d_pkg::t_ent        i_b,
    input  logic [15:0]            i_frac,
    output lut3d_pkg::t_ent        o_y
);
    import lut3d_pkg::*;

    logic signed [ENT_W:0]     r_d;
    t_ent                      r_a;
    logic [15:0]               r_f;
    logic signed [ENT_W+17:0]  r_p;
    t_ent                      r_a2;
    logic signed [16:0]        w_fs;
    logic signed [ENT_W+2:0]   w_sum;

    assign w_fs  = {1'b0, r_f};
    // a + floor((b-a)*f / 65536)
    assign w_sum = {{3{r_a2[ENT_W-1]}}, r_a2} + {r_p[ENT_W+17], r_p[ENT_W+17:16]};

    // Difference, product, then add back
    always_ff @(posedge i_clk) begin
        r_d  <= {i_b[ENT_W-1], i_b} - {i_a[ENT_W-1], i_a};
        r_a  <= i_a;
        r_f  <= i_frac;
        r_p  <= r_d * w_fs;
        r_a2 <= r_a;
        o_y  <= w_sum[ENT_W-1:0];
    end

endmodule

// ----- rtl/lut3d_trilinear_color_map.sv -----
// Top level of the 3D LUT color mapper with trilinear interpolation.
//
// Usage: the slave stream carries commands. tuser = 0 loads one table entry
// (index and three signed 18-bit values, 65535 = 1.0); tuser = 1 maps one
// 16-bit RGB pixel, tlast marks the last pixel of an image. The master
// stream returns one clamped RGB result per pixel, none per load, with
// tlast copied from the pixel.
// The config channel writes lut_size (index 0) and lut_mode (index 1);
// write it only while no pixel is in flight.
// Throughput: one transaction per cycle while tready is high. The table is
// held in four dual-read memory copies, so all eight cube corners are read
// in the same cycle. An accepted pixel passes four address stages, one
// memory read, three blend levels of three stages each and one output
// queue before its result appears on the master side.
// Stalls: results land in a 16-deep output queue; tready on the slave
// side drops only when queued plus in-flight pixels would fill it, so
// nothing in the pipeline ever stops or is lost.
// Reset: the queue and pipeline empty, lut_size = 33, lut_mode = cube.
// Table contents are not cleared; read only entries already loaded.
`include "assert_macros.svh"

module lut3d_trilinear_color_map #(
    parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lut3d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lut3d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: entry_index[15:0], entry_red[33:16], entry_green[51:34],
    // entry_blue[69:52], pixel_red[85:70], pixel_green[101:86],
    // pixel_blue[117:102], zero pad[119:118]
    input  logic [lut3d_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,  // command
    input  logic                                i_s_tlast,  // last_pixel
    // Master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: out_red[15:0], out_green[31:16], out_blue[47:32]
    output logic [lut3d_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tlast   // last_out
);
    import lut3d_pkg::*;

    localparam int DEPTH      = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW         = $clog2(DEPTH);
    localparam int DW         = 3 * ENT_W;
    localparam int S_MEM      = 5;
    localparam int S_L1       = 8;
    localparam int S_L2       = 11;
    localparam int S_LAST     = 14;
    localparam int FIFO_DEPTH = 16;
    localparam int FP_W       = 4;

    // Config registers
    logic [SIZE_W-1:0] r_lut_size;
    logic              r_lut_mode;
    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] w_sm1;
    logic [11:0]       r_size_sq;

    // Stage 1: captured transaction
    logic              w_accept;
    logic              r1_vld;
    logic              r1_cmd;
    logic [15:0]       r1_idx;
    logic [DW-1:0]     r1_ent;
    logic [2:0][CH_W-1:0] r1_pix;
    logic              r1_last;
    logic              r1_mode;

    // Stage 2: grid indexes
    logic              r2_ld;
    logic [15:0]       r2_idx;
    logic [DW-1:0]     r2_ent;
    logic [2:0][SIZE_W-1:0] r2_lo;
    logic [2:0][SIZE_W-1:0] r2_hi;
    logic [2:0][SIZE_W-1:0] w_lo;
    logic [2:0][SIZE_W-1:0] w_hi;
    logic [2:0][CH_W-1:0]   w_fr;

    // Stage 3: row and plane offsets
    logic              r3_ld;
    logic [15:0]       r3_idx;
    logic [DW-1:0]     r3_ent;
    logic [2:0][SIZE_W-1:0] r3_lo;
    logic [2:0][SIZE_W-1:0] r3_hi;
    logic [11:0]       r3_glo;
    logic [11:0]       r3_ghi;
    logic [17:0]       r3_blo;
    logic [17:0]       r3_bhi;

    // Stage 4: memory addresses
    logic              r4_we;
    logic [AW-1:0]     r4_waddr;
    logic [DW-1:0]     r4_wdata;
    logic [AW-1:0]     r4_addr [8];
    logic [AW-1:0]     w_addr [8];
    logic [DW-1:0]     w_rd [8];

    // Side info and pixel valids per stage
    t_side             r_sd [2:S_LAST];
    logic              r_pv [2:S_LAST];

    // Blend levels
    t_ent              w_l1_a [3][4];
    t_ent              w_l1_b [3][4];
    logic [CH_W-1:0]   w_l1_f [3];
    t_ent              w_y1 [3][4];
    t_ent              w_y2 [3][2];
    t_ent              w_y3 [3];

    // Output queue and credit
    t_result           r_fifo [FIFO_DEPTH];
    logic [FP_W-1:0]   r_wp;
    logic [FP_W-1:0]   r_rp;
    logic [FP_W:0]     r_occ;
    logic [FP_W:0]     r_inflight;
    logic              w_push;
    logic              w_pop;
    logic              w_pix_in;
    logic [FP_W+1:0]   w_credit;
    t_result           w_res;
    t_result           w_head;

    // Effective grid size
    assign w_size = ({1'b0, r_lut_size} > 7'(MAX_GRID)) ? SIZE_W'(MAX_GRID) : r_lut_size;
    assign w_sm1  = w_size - 6'd1;

    // Config writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_size <= SIZE_RESET;
            r_lut_mode <= MODE_CUBE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LUT_SIZE: r_lut_size <= i_cfg_data;
                CFG_LUT_MODE: r_lut_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_size_sq <= 12'(w_size) * 12'(w_size);
    end

    // Input handshake and credit
    assign w_credit   = {1'b0, r_occ} + {1'b0, r_inflight};
    assign o_s_tready = (w_credit < (FP_W+2)'(FIFO_DEPTH));
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pix_in   = w_accept && (i_s_tuser == CMD_PIXEL);

    // Stage 1: capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
        end
        r1_cmd  <= i_s_tuser;
        r1_idx  <= i_s_tdata[15:0];
        r1_ent  <= i_s_tdata[69:16];
        r1_pix  <= i_s_tdata[117:70];
        r1_last <= i_s_tlast;
        r1_mode <= r_lut_mode;
    end

    // Stage 2: scale channels into index and fraction
    always_comb begin
        logic [21:0] pos;
        logic [6:0]  hi7;
        for (int c = 0; c < 3; c++) begin
            pos     = 22'(r1_pix[c]) * 22'(w_sm1);
            w_lo[c] = pos[21:16];
            w_fr[c] = pos[15:0];
            hi7     = {1'b0, pos[21:16]} + 7'd1;
            w_hi[c] = (hi7 > {1'b0, w_sm1}) ? w_sm1 : hi7[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ld   <= 1'b0;
            r_pv[2] <= 1'b0;
        end else begin
            r2_ld   <= r1_vld && (r1_cmd == CMD_LOAD);
            r_pv[2] <= r1_vld && (r1_cmd == CMD_PIXEL);
        end
        r2_idx       <= r1_idx;
        r2_ent       <= r1_ent;
        r2_lo        <= w_lo;
        r2_hi        <= w_hi;
        r_sd[2].last <= r1_last;
        r_sd[2].pass <= (w_size <= 6'd1);
        r_sd[2].mode <= r1_mode;
        r_sd[2].pix  <= r1_pix;
        r_sd[2].fr   <= w_fr;
    end

    // Stage 3: green row and blue plane offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ld <= 1'b0;
        end else begin
            r3_ld <= r2_ld;
        end
        r3_idx <= r2_idx;
        r3_ent <= r2_ent;
        r3_lo  <= r2_lo;
        r3_hi  <= r2_hi;
        r3_glo <= 12'(r2_lo[1]) * 12'(w_size);
        r3_ghi <= 12'(r2_hi[1]) * 12'(w_size);
        r3_blo <= 18'(r2_lo[2]) * 18'(r_size_sq);
        r3_bhi <= 18'(r2_hi[2]) * 18'(r_size_sq);
    end

    // Stage 4: eight corner addresses, or six curve points
    always_comb begin
        logic [18:0] sum;
        for (int k = 0; k < 8; k++) begin
            sum = 19'(k[0] ? r3_hi[0] : r3_lo[0])
                + 19'(k[1] ? r3_ghi : r3_glo)
                + 19'(k[2] ? r3_bhi : r3_blo);
            if (r_sd[3].mode == MODE_CUBE) begin
                w_addr[k] = AW'(sum);
            end else if (k < 6) begin
                w_addr[k] = AW'(k[0] ? r3_hi[k/2] : r3_lo[k/2]);
            end else begin
                w_addr[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_we <= 1'b0;
        end else begin
            r4_we <= r3_ld && (32'(r3_idx) < DEPTH);
        end
        r4_waddr <= AW'(r3_idx);
        r4_wdata <= r3_ent;
        for (int k = 0; k < 8; k++) begin
            r4_addr[k] <= w_addr[k];
        end
    end

    // Stage 5: table copies, each serving two corners
    for (genvar j = 0; j < 4; j++) begin : g_ram
        lut3d_ram #(
            .DEPTH (DEPTH),
            .AW    (AW),
            .DW    (DW)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (r4_we),
            .i_waddr   (r4_waddr),
            .i_wdata   (r4_wdata),
            .i_raddr_a (r4_addr[2*j]),
            .i_raddr_b (r4_addr[2*j+1]),
            .o_rdata_a (w_rd[2*j]),
            .o_rdata_b (w_rd[2*j+1])
        );
    end

    // Advance side info and valids
    for (genvar s = 3; s <= S_LAST; s++) begin : g_adv
        always_ff @(posedge i_clk) begin
            r_sd[s] <= r_sd[s-1];
            if (!i_rst_n) begin
                r_pv[s] <= 1'b0;
            end else begin
                r_pv[s] <= r_pv[s-1];
            end
        end
    end

    // First blend level: along red in cube mode, along the curve otherwise
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_l1_f[c] = (r_sd[S_MEM].mode == MODE_CUBE) ? r_sd[S_MEM].fr[0]
                                                        : r_sd[S_MEM].fr[c];
            for (int p = 0; p < 4; p++) begin
                if (r_sd[S_MEM].mode == MODE_CUBE) begin
                    w_l1_a[c][p] = w_rd[2*p][ENT_W*c +: ENT_W];
                    w_l1_b[c][p] = w_rd[2*p+1][ENT_W*c +: ENT_W];
                end else begin
                    w_l1_a[c][p] = w_rd[2*c][ENT_W*c +: ENT_W];
                    w_l1_b[c][p] = w_rd[2*c+1][ENT_W*c +: ENT_W];
                end
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        for (genvar p = 0; p < 4; p++) begin : g_l1
            lut3d_lerp u_lerp (
                .i_clk  (i_clk),
                .i_a    (w_l1_a[c][p]),
                .i_b    (w_l1_b[c][p]),
                .i_frac (w_l1_f[c]),
                .o_y    (w_y1[c][p])
            );
        end
        // Second level: along green
        for (genvar q = 0; q < 2; q++) begin : g_l2
            lut3d_lerp u_lerp (
                .i_clk  (i_clk),
                .i_a    (w_y1[c][2*q]),
                .i_b    (w_y1[c][2*q+1]),
                .i_frac (r_sd[S_L1].fr[1]),
                .o_y    (w_y2[c][q])
            );
        end
        // Third level: along blue
        lut3d_lerp u_l3 (
            .i_clk  (i_clk),
            .i_a    (w_y2[c][0]),
            .i_b    (w_y2[c][1]),
            .i_frac (r_sd[S_L2].fr[2]),
            .o_y    (w_y3[c])
        );
    end

    // Clamp or pass the pixel through
    always_comb begin
        w_res.last = r_sd[S_LAST].last;
        for (int c = 0; c < 3; c++) begin
            w_res.rgb[c] = r_sd[S_LAST].pass ? r_sd[S_LAST].pix[c] : clamp16(w_y3[c]);
        end
    end

    // Output queue
    assign w_push     = r_pv[S_LAST];
    assign w_head     = r_fifo[r_rp];
    assign o_m_tvalid = (r_occ != '0);
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = w_head.rgb;
    assign o_m_tlast  = w_head.last;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_occ      <= '0;
            r_inflight <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_occ      <= r_occ + (FP_W+1)'(w_push) - (FP_W+1)'(w_pop);
            r_inflight <= r_inflight + (FP_W+1)'(w_pix_in) - (FP_W+1)'(w_push);
        end
    end

    // Checks
    `ASSERT_CLK(a_credit_bound, w_credit <= (FP_W+2)'(FIFO_DEPTH), "queue credit overrun")
    `ASSERT_IMPL(a_push_room, w_push, (r_occ < (FP_W+1)'(FIFO_DEPTH)) || w_pop, "queue overflow")
    `ASSERT_IMPL(a_push_owned, w_push, r_inflight != '0, "result without pixel in flight")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the 3D LUT color mapper: directed table, then random phases.
module tb_top;
    import lut3d_pkg::*;

    localparam int DEPTH     = 35937;
    localparam int WD_LIMIT  = 5000;
    localparam int IDLE_WAIT = 24;

    typedef struct {
        logic            is_cfg;
        logic [7:0]      cfg_idx;
        logic [5:0]      cfg_dat;
        logic            cmd;
        logic [15:0]     idx;
        t_ent            er, eg, eb;
        logic [15:0]     pr, pg, pb;
        logic            last;
        logic            has_exp;
        logic [47:0]     exp_rgb;
    } t_row;

    typedef struct {
        logic [47:0] rgb;
        logic        last;
    } t_pix_exp;

    logic        i_clk, i_rst_n;
    logic        i_cfg_valid, o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [5:0]  i_cfg_data;
    logic        i_s_tvalid, o_s_tready;
    logic [119:0] i_s_tdata;
    logic        i_s_tuser, i_s_tlast;
    logic        o_m_tvalid, i_m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    t_ent        lut_mem [0:DEPTH-1][0:2];
    bit          loaded [0:DEPTH-1];
    logic [5:0]  cur_size;
    logic        cur_mode;
    t_pix_exp    pix_q[$];
    int          errs;
    bit          quiet;
    int          stall_cnt;

    lut3d_trilinear_color_map dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Blend two values along one axis, floor toward minus infinity
    function automatic int blend(int a, int b, int fr);
        longint x;
        x = longint'(a) * (65536 - fr) + longint'(b) * fr;
        return int'(x >>> 16);
    endfunction

    function automatic logic [15:0] sat16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic int corner(int r, int g, int b, int sz, int ch);
        int a;
        a = r + g * sz + b * sz * sz;
        if (a >= DEPTH) return 0;
        return int'(lut_mem[a][ch]);
    endfunction

    // Predict the mapped pixel {blue, green, red}
    function automatic logic [47:0] map_pixel(logic [15:0] pr, logic [15:0] pg,
                                              logic [15:0] pb);
        int sz, c, v, pos;
        int lo[3], hi[3], fr[3], px[3];
        int x00, x10, x01, x11, y0, y1;
        logic [47:0] res;
        px[0] = pr; px[1] = pg; px[2] = pb;
        sz = (cur_size > 33) ? 33 : cur_size;
        if (sz <= 1) return {pb, pg, pr};
        for (c = 0; c < 3; c++) begin
            pos = px[c] * (sz - 1);
            lo[c] = pos >> 16;
            fr[c] = pos & 16'hFFFF;
            hi[c] = lo[c] + 1;
            if (lo[c] > sz - 1) lo[c] = sz - 1;
            if (hi[c] > sz - 1) hi[c] = sz - 1;
        end
        for (c = 0; c < 3; c++) begin
            if (cur_mode == MODE_CURVE) begin
                v = blend(lut_mem[lo[c]][c], lut_mem[hi[c]][c], fr[c]);
            end else begin
                x00 = blend(corner(lo[0], lo[1], lo[2], sz, c),
                            corner(hi[0], lo[1], lo[2], sz, c), fr[0]);
                x10 = blend(corner(lo[0], hi[1], lo[2], sz, c),
                            corner(hi[0], hi[1], lo[2], sz, c), fr[0]);
                x01 = blend(corner(lo[0], lo[1], hi[2], sz, c),
                            corner(hi[0], lo[1], hi[2], sz, c), fr[0]);
                x11 = blend(corner(lo[0], hi[1], hi[2], sz, c),
                            corner(hi[0], hi[1], hi[2], sz, c), fr[0]);
                y0 = blend(x00, x10, fr[1]);
                y1 = blend(x01, x11, fr[1]);
                v = blend(y0, y1, fr[2]);
            end
            res[c*16 +: 16] = sat16(v);
        end
        return res;
    endfunction

    // Send one transaction on the slave stream; starts and ends at a falling edge
    task automatic send_item(input logic cmd, input logic [15:0] idx,
                             input t_ent er, input t_ent eg, input t_ent eb,
                             input logic [15:0] pr, input logic [15:0] pg,
                             input logic [15:0] pb, input logic last,
                             input logic has_exp, input logic [47:0] exp_rgb);
        t_pix_exp e;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tlast  = last;
        i_s_tdata  = {2'b00, pb, pg, pr, eb, eg, er, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // Update the table or queue the expected pixel
        if (cmd == CMD_LOAD) begin
            if (idx < DEPTH) begin
                lut_mem[idx][0] = er;
                lut_mem[idx][1] = eg;
                lut_mem[idx][2] = eb;
                loaded[idx]     = 1'b1;
            end
        end else begin
            e.rgb  = has_exp ? exp_rgb : map_pixel(pr, pg, pb);
            e.last = last;
            pix_q.push_back(e);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // Load one table entry with random values unless it holds data already
    task automatic load_entry(input int a);
        if (!loaded[a])
            send_item(CMD_LOAD, a[15:0], t_ent'($urandom), t_ent'($urandom),
                      t_ent'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b0, 1'b0, '0);
    endtask

    // Load every entry that a pixel will read and that is still empty
    task automatic prep_pixel(input logic [15:0] pr, input logic [15:0] pg,
                              input logic [15:0] pb);
        int sz, c, k, pos;
        int lo[3], hi[3], px[3];
        px[0] = pr; px[1] = pg; px[2] = pb;
        sz = (cur_size > 33) ? 33 : cur_size;
        if (sz <= 1) return;
        for (c = 0; c < 3; c++) begin
            pos = px[c] * (sz - 1);
            lo[c] = pos >> 16;
            hi[c] = lo[c] + 1;
            if (lo[c] > sz - 1) lo[c] = sz - 1;
            if (hi[c] > sz - 1) hi[c] = sz - 1;
        end
        if (cur_mode == MODE_CURVE) begin
            for (c = 0; c < 3; c++) begin
                load_entry(lo[c]);
                load_entry(hi[c]);
            end
        end else begin
            for (k = 0; k < 8; k++)
                load_entry((k[0] ? hi[0] : lo[0]) + (k[1] ? hi[1] : lo[1]) * sz
                           + (k[2] ? hi[2] : lo[2]) * sz * sz);
        end
    endtask

    // Hold off until every expected pixel is out and the pipeline has drained
    task automatic drain_wait();
        while (pix_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [7:0] ridx, input logic [5:0] rdat);
        drain_wait();
        i_cfg_valid = 1'b1;
        i_cfg_index = ridx;
        i_cfg_data  = rdat;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (ridx == CFG_LUT_SIZE) cur_size = rdat;
        else if (ridx == CFG_LUT_MODE) cur_mode = rdat[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_row item_row(logic cmd, logic [15:0] idx, t_ent ev,
                                      logic [15:0] pv, logic last, logic has_exp,
                                      logic [47:0] exp_rgb);
        t_row r;
        r = '{default: '0};
        r.cmd = cmd; r.idx = idx;
        r.er = ev; r.eg = ev; r.eb = ev;
        r.pr = pv; r.pg = ~pv; r.pb = pv ^ 16'h5A5A;
        r.last = last; r.has_exp = has_exp; r.exp_rgb = exp_rgb;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [7:0] ridx, logic [5:0] rdat);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.cfg_idx = ridx; r.cfg_dat = rdat;
        return r;
    endfunction

    // Receiver: random stall bursts on the master side
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 15) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_pix_exp e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pix_q.size() == 0) begin
                $error("unexpected result rgb=%h last=%b", o_m_tdata, o_m_tlast);
                errs++;
            end else begin
                e = pix_q.pop_front();
                if (o_m_tdata[15:0] !== e.rgb[15:0]) begin
                    $error("out_red expected %h actual %h", e.rgb[15:0], o_m_tdata[15:0]);
                    errs++;
                end
                if (o_m_tdata[31:16] !== e.rgb[31:16]) begin
                    $error("out_green expected %h actual %h", e.rgb[31:16],
                           o_m_tdata[31:16]);
                    errs++;
                end
                if (o_m_tdata[47:32] !== e.rgb[47:32]) begin
                    $error("out_blue expected %h actual %h", e.rgb[47:32],
                           o_m_tdata[47:32]);
                    errs++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last_out expected %b actual %b", e.last, o_m_tlast);
                    errs++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_row        rows[$];
        t_row        r;
        int          ph, n, k, sz, span;
        logic [5:0]  psize;
        logic        mbit;
        logic [15:0] pv[3];
        logic [15:0] lidx;
        errs = 0; quiet = 1'b0; stall_cnt = 0;
        cur_size = SIZE_RESET; cur_mode = MODE_CUBE;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = 1'b0; i_s_tlast = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: clamp extremes, pass-through, edge indices, odd registers
        rows.push_back(cfg_row(CFG_LUT_SIZE, 6'd2));
        rows.push_back(cfg_row(CFG_LUT_MODE, {5'b0, MODE_CURVE}));
        rows.push_back(item_row(CMD_LOAD, 16'd0, 18'sh1FFFF, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_LOAD, 16'd1, 18'sh1FFFF, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h0000, 1'b0, 1'b1, '1));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'hFFFF, 1'b1, 1'b1, '1));
        rows.push_back(item_row(CMD_LOAD, 16'd0, -18'sd131072, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_LOAD, 16'd1, -18'sd131072, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h9C31, 1'b0, 1'b1, '0));
        // Loads beyond the table are dropped
        rows.push_back(item_row(CMD_LOAD, 16'd35937, 18'sh1FFFF, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_LOAD, 16'hFFFF, 18'sh2AAAA, 16'h0, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h4000, 1'b1, 1'b0, '0));
        // Sizes 0 and 1 pass the pixel through
        rows.push_back(cfg_row(CFG_LUT_SIZE, 6'd0));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'hFFFF, 1'b1, 1'b1,
                                {16'hFFFF ^ 16'h5A5A, 16'h0000, 16'hFFFF}));
        rows.push_back(cfg_row(CFG_LUT_SIZE, 6'd1));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h1234, 1'b0, 1'b1,
                                {16'h1234 ^ 16'h5A5A, ~16'h1234, 16'h1234}));
        // Oversized register acts as the largest grid
        rows.push_back(cfg_row(CFG_LUT_SIZE, 6'd63));
        rows.push_back(cfg_row(CFG_LUT_MODE, {5'b0, MODE_CUBE}));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'hFFFF, 1'b0, 1'b0, '0));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h0000, 1'b1, 1'b0, '0));
        // Unknown register indexes change nothing
        rows.push_back(cfg_row(8'd2, 6'h3F));
        rows.push_back(cfg_row(8'hFF, 6'h00));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'h8000, 1'b0, 1'b0, '0));
        rows.push_back(cfg_row(CFG_LUT_SIZE, 6'd33));
        rows.push_back(item_row(CMD_PIXEL, 16'd0, 18'sd0, 16'hFFFF, 1'b1, 1'b0, '0));

        foreach (rows[i]) begin
            r = rows[i];
            if (r.is_cfg) begin
                write_reg(r.cfg_idx, r.cfg_dat);
            end else begin
                if (r.cmd == CMD_PIXEL) prep_pixel(r.pr, r.pg, r.pb);
                send_item(r.cmd, r.idx, r.er, r.eg, r.eb, r.pr, r.pg, r.pb,
                          r.last, r.has_exp, r.exp_rgb);
            end
        end

        // Random phases over sizes and modes; large grids run as curves
        for (ph = 0; ph < 14; ph++) begin
            case (ph)
                0, 8:    psize = 6'd2;
                1:       psize = 6'd3;
                2, 13:   psize = 6'd33;
                3:       psize = 6'd0;
                4:       psize = 6'd1;
                5:       psize = 6'(34 + $urandom_range(0, 29));
                6:       psize = 6'd5;
                default: psize = 6'($urandom_range(2, 33));
            endcase
            if (ph >= 12) quiet = 1'b1;
            sz = (psize > 33) ? 33 : psize;
            if (sz > 6) mbit = MODE_CURVE;
            else if (ph % 2 == 0) mbit = MODE_CUBE;
            else mbit = 1'($urandom);
            write_reg(CFG_LUT_SIZE, psize);
            write_reg(CFG_LUT_MODE, {5'($urandom), mbit});
            span = (sz <= 1) ? DEPTH : ((cur_mode == MODE_CUBE) ? sz * sz * sz : sz);
            n = $urandom_range(80, 95);
            for (k = 0; k < n; k++) begin
                if (ph == 7 && k == n / 2) drain_wait();
                for (int c = 0; c < 3; c++) begin
                    case ($urandom_range(0, 9))
                        0:       pv[c] = 16'h0000;
                        1:       pv[c] = 16'hFFFF;
                        default: pv[c] = 16'($urandom);
                    endcase
                end
                if ($urandom_range(0, 7) == 0) begin
                    lidx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, span - 1));
                    send_item(CMD_LOAD, lidx, t_ent'($urandom), t_ent'($urandom),
                              t_ent'($urandom), pv[0], pv[1], pv[2], 1'($urandom),
                              1'b0, '0);
                end else begin
                    prep_pixel(pv[0], pv[1], pv[2]);
                    send_item(CMD_PIXEL, 16'($urandom), t_ent'($urandom),
                              t_ent'($urandom), t_ent'($urandom), pv[0], pv[1], pv[2],
                              ($urandom_range(0, 15) == 0), 1'b0, '0);
                end
            end
        end

        drain_wait();
        repeat (20) @(negedge i_clk);
        if (errs == 0 && pix_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lut3d_pkg.sv
rtl/lut3d_ram.sv
rtl/lut3d_lerp.sv
rtl/lut3d_trilinear_color_map.sv
sim/tb_top.sv
